FILE: rtl/rc4sc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC4 stream cipher package
// Sequencer states, permutation memory request type and fixed sizes.
// ----------------------------------------------------------------------------
package rc4sc_pkg;

  localparam int PERM_DEPTH = 256;
  localparam int PERM_AW    = 8;

  typedef enum logic [3:0] {
    S_IDLE,
    S_K_RD,
    S_K_MIX,
    S_K_WR_R,
    S_K_WR_M,
    S_D_RD_I,
    S_D_RD_J,
    S_D_SWAP,
    S_D_OUT
  } seq_state_t;

  // One write port, one read port and a clear that returns the memory to identity.
  typedef struct packed {
    logic               clear;
    logic               we;
    logic [PERM_AW-1:0] waddr;
    logic [7:0]         wdata;
    logic [PERM_AW-1:0] raddr;
  } perm_req_t;

endpackage

FILE: rtl/rc4sc_perm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC4 permutation memory
// 256 x 8 memory with registered read. Per-entry valid bits make an entry
// that was not written since the last clear read as its own address, so the
// identity permutation is restored by a clear or a reset.
// ----------------------------------------------------------------------------
module rc4sc_perm_ram import rc4sc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  perm_req_t          req,
  output logic [7:0]         rd_data
);

  logic [7:0]            mem [PERM_DEPTH];
  logic [PERM_DEPTH-1:0] vld;
  logic [7:0]            rd_word;
  logic                  rd_vld;
  logic [PERM_AW-1:0]    rd_addr;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_word <= mem[req.raddr];
    rd_addr <= req.raddr;
  end

  always_ff @(posedge clk) begin
    if (rst || req.clear) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (req.we) begin
        vld[req.waddr] <= 1'b1;
      end
      rd_vld <= vld[req.raddr];
    end
  end

  assign rd_data = rd_vld ? rd_word : rd_addr;

endmodule

FILE: rtl/rc4_stream_cipher_core.sv
// Key byte: taken while the core is idle. Last key byte: the key schedule
// follows, 256 rounds of the states K_RD, K_MIX, K_WR_R and K_WR_M on the
// permutation memory, during which no item is taken. Data byte: no new byte
// is taken until its result is loaded, which waits on the three dependent
// registered reads of the permutation memory. Reset restores the identity
// permutation at once, clears both indices and empties the key store.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC4 stream cipher core
// Loads key bytes, runs the key schedule and ciphers data bytes with a
// small sequencer around one permutation memory.
// ----------------------------------------------------------------------------
module rc4_stream_cipher_core import rc4sc_pkg::*; #(
  parameter int MAX_KEY_BYTES = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       mode,
  input  logic [7:0] data_byte,
  input  logic       key_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte
);

  localparam int KIDX_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam int KCNT_W = $clog2(MAX_KEY_BYTES + 1);

  seq_state_t          state, state_next;
  perm_req_t           preq;
  logic [7:0]          pr_data;

  logic [7:0]          key_mem [MAX_KEY_BYTES];
  logic [7:0]          key_rd;
  logic [KCNT_W-1:0]   key_count;
  logic [KIDX_W-1:0]   kidx;
  logic [7:0]          round_cnt;
  logic [7:0]          mix;
  logic [7:0]          idx_i;
  logic [7:0]          idx_j;
  logic [7:0]          a_byte;
  logic [7:0]          b_byte;
  logic [7:0]          t_idx;
  logic [7:0]          din;

  logic                in_xfer;
  logic                key_room;
  logic                sched_start;
  logic                out_load;
  logic [7:0]          key_byte;
  logic [7:0]          mix_next;
  logic [7:0]          ks_byte;

  rc4sc_perm_ram u_perm (
    .clk     (clk),
    .rst     (rst),
    .req     (preq),
    .rd_data (pr_data)
  );

  assign in_stall    = (state != S_IDLE);
  assign in_xfer     = in_valid && !in_stall;
  assign key_room    = (key_count < KCNT_W'(MAX_KEY_BYTES));
  assign sched_start = in_xfer && !mode && key_last;
  assign key_byte    = (key_count == '0) ? 8'h00 : key_rd;
  assign mix_next    = mix + pr_data + key_byte;

  // The final value of s[t] after the swap: j was written last.
  assign ks_byte = (t_idx == idx_j) ? a_byte :
                   (t_idx == idx_i) ? b_byte : pr_data;

  always_comb begin
    state_next = state;
    preq       = '0;
    out_load   = 1'b0;
    case (state)
      S_IDLE: begin
        if (sched_start) begin
          preq.clear = 1'b1;
          state_next = S_K_RD;
        end else if (in_xfer && mode) begin
          state_next = S_D_RD_I;
        end
      end
      S_K_RD: begin
        preq.raddr = round_cnt;
        state_next = S_K_MIX;
      end
      S_K_MIX: begin
        preq.raddr = mix_next;
        state_next = S_K_WR_R;
      end
      S_K_WR_R: begin
        preq.we    = 1'b1;
        preq.waddr = round_cnt;
        preq.wdata = pr_data;
        state_next = S_K_WR_M;
      end
      S_K_WR_M: begin
        preq.we    = 1'b1;
        preq.waddr = mix;
        preq.wdata = a_byte;
        state_next = (round_cnt == 8'hFF) ? S_IDLE : S_K_RD;
      end
      S_D_RD_I: begin
        preq.raddr = idx_i;
        state_next = S_D_RD_J;
      end
      S_D_RD_J: begin
        preq.raddr = idx_j + pr_data;
        state_next = S_D_SWAP;
      end
      S_D_SWAP: begin
        preq.we    = 1'b1;
        preq.waddr = idx_i;
        preq.wdata = pr_data;
        preq.raddr = a_byte + pr_data;
        state_next = S_D_OUT;
      end
      S_D_OUT: begin
        preq.we    = 1'b1;
        preq.waddr = idx_j;
        preq.wdata = a_byte;
        preq.raddr = t_idx;
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Key store: written when a key byte is taken while there is room, read at the cyclic key index.
  always_ff @(posedge clk) begin
    if (in_xfer && !mode && key_room) begin
      key_mem[key_count[KIDX_W-1:0]] <= data_byte;
    end
    key_rd <= key_mem[kidx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_count <= '0;
      idx_i     <= '0;
      idx_j     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_xfer && !mode && key_room) begin
        key_count <= key_count + KCNT_W'(1);
      end else if (state == S_K_WR_M && round_cnt == 8'hFF) begin
        key_count <= '0;
      end
      if (sched_start) begin
        idx_i <= '0;
        idx_j <= '0;
      end else if (in_xfer && mode) begin
        idx_i <= idx_i + 8'd1;
      end else if (state == S_D_RD_J) begin
        idx_j <= idx_j + pr_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sched_start) begin
      round_cnt <= '0;
      mix       <= '0;
      kidx      <= '0;
    end
    if (in_xfer) begin
      din <= data_byte;
    end
    case (state)
      S_K_MIX: begin
        a_byte <= pr_data;
        mix    <= mix_next;
      end
      S_K_WR_M: begin
        round_cnt <= round_cnt + 8'd1;
        if (KCNT_W'(kidx) == key_count - KCNT_W'(1)) begin
          kidx <= '0;
        end else begin
          kidx <= kidx + KIDX_W'(1);
        end
      end
      S_D_RD_J: begin
        a_byte <= pr_data;
      end
      S_D_SWAP: begin
        b_byte <= pr_data;
        t_idx  <= a_byte + pr_data;
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_byte <= din ^ ks_byte;
    end
  end

endmodule

FILE: rtl/rc4sc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC4 stream cipher port checker
// Watches the top-level ports over time and is bound to the core.
// ----------------------------------------------------------------------------
module rc4sc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       mode,
  input logic       key_last,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte
);

  // A waiting result must hold until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte))
    else $error("result changed while stalled");

  // Reset leaves no result pending.
  a_out_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // A data byte keeps the core busy while it is ciphered.
  a_data_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && mode |=> in_stall)
    else $error("core took an item while ciphering");

  // The last key byte starts the key schedule.
  a_sched_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !mode && key_last |=> in_stall && !$rose(out_valid))
    else $error("key schedule did not start");

endmodule

bind rc4_stream_cipher_core rc4sc_checker u_rc4sc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .mode      (mode),
  .key_last  (key_last),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_byte  (out_byte)
);
